// ===== src/tmavg_pkg.sv =====
// ----------------------------------------------------------------------------
// tmavg_pkg
// Shared types and fixed field widths of the temperature moving average.
// ----------------------------------------------------------------------------
package tmavg_pkg;

  localparam int ADC_W    = 10;  // raw converter reading
  localparam int SAMPLE_W = 11;  // signed relative sample
  localparam int FRAC_W   = 8;   // fraction bits of the average
  localparam int AVG_W    = 19;  // signed average, 8 fraction bits
  localparam int QMAG_W   = 18;  // magnitude bits that the average can need
  localparam int HELD_W   = 5;   // samples_held field

  localparam logic [ADC_W-1:0] ZERO_OFFSET_RST = 10'd490;

  // Status of the bit-serial divider, seen by the control logic.
  typedef struct packed {
    logic busy;
    logic done;
  } tmavg_div_stat_t;

endpackage

// ===== src/tmavg_ram.sv =====
// ----------------------------------------------------------------------------
// tmavg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmavg_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/tmavg_div.sv =====
// ----------------------------------------------------------------------------
// tmavg_div
// Bit-serial restoring divider: one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module tmavg_div
  import tmavg_pkg::*;
#(
  parameter int DIVD_W = 22,
  parameter int DIVS_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output tmavg_div_stat_t   stat
);

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(DIVD_W);
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== src/temperature_moving_average_top.sv =====
// ----------------------------------------------------------------------------
// temperature_moving_average_top
// Boxcar moving average of relative temperature samples with warm-up.
// ----------------------------------------------------------------------------
// Each accepted item takes one raw reading, forms the sample zero_offset minus
// reading, replaces the oldest of the last WINDOW samples and returns one item
// with the mean (signed, 8 fraction bits, truncated toward zero) and the number
// of samples held. An item occupies the block from acceptance until its result
// is loaded, including a divide in the bit-serial divider, which produces one
// quotient bit per cycle of the scaled sum; no new item is taken meanwhile.
// in_stall is high while an item is in the block, and a result left waiting on
// out_stall holds the block at the end of its divide, so the next item waits.
// No clearing pass is needed after reset.
module temperature_moving_average_top
  import tmavg_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ADC_W-1:0]         cfg_zero_offset,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ADC_W-1:0]         in_adc_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [AVG_W-1:0]  out_average_q8,
  output logic [HELD_W-1:0]        out_samples_held
);

  localparam int SUM_W  = $clog2(WINDOW * 1024) + 1;
  localparam int MAG_W  = SUM_W - 1 + FRAC_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = WINDOW > 1 ? $clog2(WINDOW) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_START,
    ST_DIV
  } state_t;

  state_t                     state_r;
  logic [ADC_W-1:0]           zoff_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [CNT_W-1:0]           fill_r;
  logic                       neg_r;
  logic                       out_valid_r;
  logic signed [AVG_W-1:0]    avg_r;
  logic [HELD_W-1:0]          held_r;

  logic                       in_acc;
  logic                       full;
  logic [SAMPLE_W-1:0]        ram_rd;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SUM_W-1:0]    sum_abs;
  logic [MAG_W-1:0]           dividend;
  logic [MAG_W-1:0]           quotient;
  logic signed [AVG_W-1:0]    avg_nxt;
  logic [CNT_W+HELD_W-1:0]    held_ext;
  logic                       div_start;
  logic                       out_load;
  tmavg_div_stat_t            div_stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = state_r != ST_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign full      = fill_r == CNT_W'(WINDOW);

  // Slots are filled in order, so before the ring is full the slot being
  // overwritten has never been written; its old sample is taken as zero.
  assign old_sample = full ? $signed(ram_rd) : '0;
  assign sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);

  assign sum_abs   = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign dividend  = {sum_abs[SUM_W-2:0], {FRAC_W{1'b0}}};
  assign div_start = state_r == ST_START;

  assign avg_nxt  = neg_r ? -$signed({1'b0, quotient[QMAG_W-1:0]})
                          :  $signed({1'b0, quotient[QMAG_W-1:0]});
  assign held_ext = {{HELD_W{1'b0}}, fill_r};
  assign out_load = state_r == ST_DIV && div_stat.done && (!out_valid_r || !out_stall);

  tmavg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == ST_UPD),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_addr (slot_r),
    .rd_data (ram_rd)
  );

  tmavg_div #(
    .DIVD_W (MAG_W),
    .DIVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (fill_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zoff_r      <= ZERO_OFFSET_RST;
      sum_r       <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        zoff_r <= cfg_zero_offset;
      end
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            sample_r <= $signed({1'b0, zoff_r}) - $signed({1'b0, in_adc_sample});
            state_r  <= ST_UPD;
          end
        end
        ST_UPD: begin
          sum_r   <= sum_nxt;
          slot_r  <= slot_r == SLOT_W'(WINDOW - 1) ? '0 : slot_r + 1'b1;
          fill_r  <= full ? fill_r : fill_r + 1'b1;
          state_r <= ST_START;
        end
        ST_START: begin
          neg_r   <= sum_r[SUM_W-1];
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (out_load) begin
            avg_r       <= avg_nxt;
            held_r      <= held_ext[HELD_W-1:0];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average_q8   = avg_r;
  assign out_samples_held = held_r;

`ifndef SYNTHESIS
  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START |=> div_stat.busy)
    else $error("divider did not start");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV)
    else $error("divider busy outside the divide state");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_item_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START |-> fill_r != '0)
    else $error("divide started with an empty window");
`endif

endmodule
